### hw/rtl/skp_pkg.sv
package skp_pkg;

	// Plan and key limits.
	localparam int MAX_SHARDS = 32;
	localparam int MAX_KEYS   = 65536;

	// Field widths.
	localparam int KEY_W  = 64;
	localparam int ENT_W  = 17;
	localparam int CNT_W  = 6;
	localparam int IDX_W  = 5;
	localparam int CAP_W  = 6;
	localparam int KIND_W = 2;
	localparam int STAT_W = 2;

	// Output stream data: shard_index, first_key, entries, shard_count, padded to bytes.
	localparam int OUT_FIELDS_W = IDX_W + KEY_W + ENT_W + CNT_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

	// Command queue between the front and the back.
	localparam int CMD_DEPTH = 4;
	localparam int CMD_AW    = $clog2(CMD_DEPTH);

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD  = 2'd0,
		KIND_END   = 2'd1,
		KIND_QUERY = 2'd2
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_UNSORTED = 2'd1,
		ST_RANGE    = 2'd2,
		ST_ABSENT   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_RESULT = 2'd0,
		CMD_PLAN   = 2'd1,
		CMD_QUERY  = 2'd2
	} cmd_op_t;

	typedef enum logic {
		REG_SHARD_SIZE     = 1'b0,
		REG_SHARD_CAPACITY = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		BK_IDLE   = 2'd0,
		BK_READ   = 2'd1,
		BK_QEMIT  = 2'd2,
		BK_SINGLE = 2'd3
	} back_state_t;

	typedef struct packed {
		cmd_op_t            op;
		status_t            status;
		logic [CNT_W-1:0]   shards;
		logic [ENT_W-1:0]   count;
		logic [ENT_W-1:0]   mn;
		logic [KEY_W-1:0]   key;
	} cmd_t;

	typedef struct packed {
		status_t            status;
		logic [IDX_W-1:0]   shard_index;
		logic [KEY_W-1:0]   first_key;
		logic [ENT_W-1:0]   entries;
		logic [CNT_W-1:0]   shard_count;
		logic               last;
	} result_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic busy;
	} back_status_t;

	typedef struct packed {
		logic               we;
		logic [IDX_W-1:0]   addr;
		logic [KEY_W-1:0]   data;
	} ram_wr_t;

endpackage

### hw/rtl/skp_ram.sv
module skp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one read port with registered data that holds when not read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/skp_front.sv
module skp_front import skp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [KIND_W-1:0] in_kind,
	input  logic [KEY_W-1:0]  in_key,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [ENT_W-1:0]  cfg_data,
	input  back_status_t      back_st,
	output logic              cmd_push,
	output cmd_t              cmd,
	output ram_wr_t           ram_wr
);

	logic [ENT_W-1:0] min_q;
	logic [CAP_W-1:0] cap_q;
	logic [KEY_W-1:0] prev_q;
	logic [ENT_W-1:0] kcnt_q;
	logic [ENT_W-1:0] fill_q;
	logic [CNT_W-1:0] groups_q;
	logic             fault_q;
	logic [CNT_W-1:0] plan_q;

	kind_t            kind;
	logic             accept;
	logic [ENT_W-1:0] mn;
	logic [ENT_W:0]   fill_next;
	logic             group_done;
	logic [CAP_W-1:0] cap;
	logic [CNT_W-1:0] shards;
	logic             end_ok;

	assign kind      = kind_t'(in_kind);
	assign cfg_ready = 1'b1;

	// Loads touch the start memory, so they wait until the back has drained.
	always_comb begin
		case (kind)
			KIND_LOAD:  in_ready = back_st.empty && !back_st.busy;
			KIND_END:   in_ready = !back_st.full;
			KIND_QUERY: in_ready = !back_st.full;
			default:    in_ready = 1'b1;
		endcase
	end

	assign accept = in_valid && in_ready;

	assign mn         = (min_q == '0) ? ENT_W'(1) : min_q;
	assign fill_next  = {1'b0, fill_q} + (ENT_W+1)'(1);
	assign group_done = fill_next >= {1'b0, mn};
	assign cap        = (cap_q > CAP_W'(MAX_SHARDS)) ? CAP_W'(MAX_SHARDS) : cap_q;
	assign shards     = (groups_q == '0) ? CNT_W'(1) : groups_q;

	// Classify end and query items into one command for the back.
	always_comb begin
		cmd        = '0;
		cmd.op     = CMD_RESULT;
		cmd.status = ST_OK;
		cmd.count  = kcnt_q;
		cmd.mn     = mn;
		cmd.key    = in_key;
		end_ok     = 1'b0;
		case (kind)
			KIND_END: begin
				if (fault_q) begin
					cmd.status = ST_UNSORTED;
				end else if (kcnt_q > ENT_W'(MAX_KEYS)) begin
					cmd.status = ST_RANGE;
				end else if (kcnt_q == '0) begin
					cmd.status = ST_OK;
				end else if (shards > cap) begin
					cmd.status = ST_RANGE;
				end else begin
					cmd.op     = CMD_PLAN;
					cmd.shards = shards;
					end_ok     = 1'b1;
				end
			end
			KIND_QUERY: begin
				if (plan_q == '0) begin
					cmd.status = ST_ABSENT;
				end else begin
					cmd.op     = CMD_QUERY;
					cmd.shards = plan_q;
				end
			end
			default: begin
				cmd.op = CMD_RESULT;
			end
		endcase
	end

	assign cmd_push = accept && (kind == KIND_END || kind == KIND_QUERY);

	// The first key of each group is stored as a shard start.
	assign ram_wr.we   = accept && kind == KIND_LOAD && fill_q == '0
		&& groups_q < CNT_W'(MAX_SHARDS);
	assign ram_wr.addr = groups_q[IDX_W-1:0];
	assign ram_wr.data = in_key;

	// Configuration registers and the load state of the list being built.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q    <= ENT_W'(1);
			cap_q    <= CAP_W'(MAX_SHARDS);
			prev_q   <= '0;
			kcnt_q   <= '0;
			fill_q   <= '0;
			groups_q <= '0;
			fault_q  <= 1'b0;
			plan_q   <= '0;
		end else begin
			if (cfg_valid) begin
				case (reg_index_t'(cfg_index))
					REG_SHARD_SIZE:     min_q <= cfg_data;
					REG_SHARD_CAPACITY: cap_q <= cfg_data[CAP_W-1:0];
					default:            min_q <= min_q;
				endcase
			end
			if (accept) begin
				case (kind)
					KIND_LOAD: begin
						plan_q <= '0;
						if (kcnt_q != '0 && in_key < prev_q) begin
							fault_q <= 1'b1;
						end
						prev_q <= in_key;
						if (kcnt_q <= ENT_W'(MAX_KEYS)) begin
							kcnt_q <= kcnt_q + ENT_W'(1);
						end
						if (group_done) begin
							fill_q <= '0;
							if (groups_q <= CNT_W'(MAX_SHARDS)) begin
								groups_q <= groups_q + CNT_W'(1);
							end
						end else begin
							fill_q <= fill_next[ENT_W-1:0];
						end
					end
					KIND_END: begin
						prev_q   <= '0;
						kcnt_q   <= '0;
						fill_q   <= '0;
						groups_q <= '0;
						fault_q  <= 1'b0;
						plan_q   <= end_ok ? shards : '0;
					end
					default: begin
						plan_q <= plan_q;
					end
				endcase
			end
		end
	end

endmodule

### hw/rtl/skp_cmd_fifo.sv
module skp_cmd_fifo import skp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	input  logic pop,
	output cmd_t head,
	output logic empty,
	output logic full
);

	cmd_t              slot_q [CMD_DEPTH];
	logic [CMD_AW-1:0] wr_ptr_q;
	logic [CMD_AW-1:0] rd_ptr_q;
	logic [CMD_AW:0]   fill_q;

	assign empty = fill_q == '0;
	assign full  = fill_q == (CMD_AW+1)'(CMD_DEPTH);
	assign head  = slot_q[rd_ptr_q];

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + CMD_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + CMD_AW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (CMD_AW+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (CMD_AW+1)'(1);
			end
		end
	end

	// Command storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### hw/rtl/skp_back.sv
module skp_back import skp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  cmd_t             cmd_in,
	output logic             cmd_pop,
	output logic             ram_re,
	output logic [IDX_W-1:0] ram_raddr,
	input  logic [KEY_W-1:0] ram_rdata,
	output logic             out_valid,
	input  logic             out_ready,
	output result_t          out_res,
	output logic             busy
);

	back_state_t      state_q;
	back_state_t      state_d;
	cmd_t             cmd_q;
	logic [IDX_W-1:0] idx_q;
	logic [ENT_W-1:0] remain_q;
	logic [IDX_W-1:0] found_idx_q;
	logic [KEY_W-1:0] found_key_q;
	logic             out_valid_q;
	result_t          out_q;

	logic             slot_free;
	logic             is_last;
	logic             take;
	logic             emit;
	result_t          res_d;

	assign slot_free = !out_valid_q || out_ready;
	assign is_last   = {1'b0, idx_q} == (cmd_q.shards - CNT_W'(1));
	assign take      = idx_q == '0 || cmd_q.key >= ram_rdata;
	assign busy      = state_q != BK_IDLE;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					case (cmd_in.op)
						CMD_PLAN:  state_d = BK_READ;
						CMD_QUERY: state_d = BK_READ;
						default:   state_d = BK_SINGLE;
					endcase
				end
			end
			BK_READ: begin
				if (cmd_q.op == CMD_PLAN) begin
					if (slot_free && is_last) begin
						state_d = BK_IDLE;
					end
				end else if (is_last) begin
					state_d = BK_QEMIT;
				end
			end
			BK_QEMIT: begin
				if (slot_free) begin
					state_d = BK_IDLE;
				end
			end
			BK_SINGLE: begin
				if (slot_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Outputs: queue pop, start memory reads and the result to register.
	always_comb begin
		cmd_pop   = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		emit      = 1'b0;
		res_d     = '0;
		res_d.last = 1'b1;
		case (state_q)
			BK_IDLE: begin
				cmd_pop = cmd_valid;
				ram_re  = cmd_valid;
			end
			BK_READ: begin
				if (cmd_q.op == CMD_PLAN) begin
					emit              = slot_free;
					res_d.status      = ST_OK;
					res_d.shard_index = idx_q;
					res_d.first_key   = ram_rdata;
					res_d.entries     = is_last ? remain_q : cmd_q.mn;
					res_d.shard_count = cmd_q.shards;
					res_d.last        = is_last;
					ram_re            = slot_free && !is_last;
				end else begin
					ram_re = !is_last;
				end
				ram_raddr = idx_q + IDX_W'(1);
			end
			BK_QEMIT: begin
				emit              = slot_free;
				res_d.status      = ST_OK;
				res_d.shard_index = found_idx_q;
				res_d.first_key   = found_key_q;
				res_d.shard_count = cmd_q.shards;
			end
			BK_SINGLE: begin
				emit         = slot_free;
				res_d.status = cmd_q.status;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the current command and the output register.
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q    <= cmd_in;
			idx_q    <= '0;
			remain_q <= cmd_in.count;
		end else if (state_q == BK_READ) begin
			if (cmd_q.op == CMD_PLAN) begin
				if (slot_free && !is_last) begin
					idx_q    <= idx_q + IDX_W'(1);
					remain_q <= (remain_q > cmd_q.mn) ? remain_q - cmd_q.mn : '0;
				end
			end else begin
				if (take) begin
					found_idx_q <= idx_q;
					found_key_q <= ram_rdata;
				end
				if (!is_last) begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
		if (emit) begin
			out_q <= res_d;
		end
	end

endmodule

### hw/rtl/sorted_key_range_partitioner_core.sv
// Sorted key range partitioner.
// The input stream (s_axis) carries one item per transfer: tuser is the kind
// (load key, end of list, query) and tdata the 64-bit key. Load keys must be
// non-decreasing; the first key of each group of shard-size keys is kept as a
// shard start. An end
// item emits the plan on m_axis, one record per shard with tlast on the final
// one, or a single error or empty result. A query emits one result naming the
// last shard whose start is at or below the key. tuser on m_axis is the status.
// The cfg channel writes the shard size (index 0) and shard_capacity (index 1).
// Load items are taken one per cycle while no end or query is in progress.
// End and query items enter a four-deep command queue; the back
// end walks the 32-entry shard start memory through its single read port.
// A plan streams out one record per shard, and a query is a linear scan
// of the start memory. Results sit in an output register, so a stalled
// receiver holds the back end; the front keeps queueing end and query items
// until the queue is full, while load items wait for the back to drain.
// Reset clears all control state: no plan, shard size 1, shard_capacity 32.
module sorted_key_range_partitioner_core import skp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [KIND_W-1:0]     s_axis_tuser,  // kind
	input  logic [KEY_W-1:0]      s_axis_tdata,  // key
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [STAT_W-1:0]     m_axis_tuser,  // status
	// shard_index, first_key, entries, shard_count, zero padding
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [ENT_W-1:0]      cfg_data
);

	back_status_t     bk_st;
	logic             cmd_push;
	cmd_t             cmd;
	cmd_t             cmd_head;
	logic             cmd_pop;
	logic             fifo_empty;
	logic             fifo_full;
	logic             back_busy;
	ram_wr_t          ram_wr;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [KEY_W-1:0] ram_rdata;
	result_t          res;

	assign bk_st.empty = fifo_empty;
	assign bk_st.full  = fifo_full;
	assign bk_st.busy  = back_busy;

	skp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_kind   (s_axis_tuser),
		.in_key    (s_axis_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.back_st   (bk_st),
		.cmd_push  (cmd_push),
		.cmd       (cmd),
		.ram_wr    (ram_wr)
	);

	skp_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd),
		.pop       (cmd_pop),
		.head      (cmd_head),
		.empty     (fifo_empty),
		.full      (fifo_full)
	);

	skp_ram #(
		.WIDTH (KEY_W),
		.DEPTH (MAX_SHARDS)
	) u_starts (
		.clk   (clk),
		.we    (ram_wr.we),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	skp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!fifo_empty),
		.cmd_in    (cmd_head),
		.cmd_pop   (cmd_pop),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res),
		.busy      (back_busy)
	);

	// Pack the result onto the output stream.
	assign m_axis_tuser = res.status;
	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res.shard_count, res.entries,
		res.first_key, res.shard_index};
	assign m_axis_tlast = res.last;

`ifndef ASSERT_OFF
	// A load transfer only happens once all queued work has drained.
	a_load_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_LOAD)
		|-> (fifo_empty && !back_busy))
		else $error("load accepted while commands pending");

	// The front never overfills the command queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !fifo_full)
		else $error("command queue overflow");

	// The start memory is never written while the back end reads it.
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr.we |-> !back_busy)
		else $error("start memory written during a plan or query");

	// A query in its emit state with the output empty always emits its result.
	a_query_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(u_back.state_q == BK_QEMIT && !m_axis_tvalid) |=> m_axis_tvalid)
		else $error("query result not emitted");
`endif

endmodule

### sim/sorted_key_range_partitioner_core_tb.sv
`timescale 1ns / 1ps

module sorted_key_range_partitioner_core_tb;
	import skp_pkg::*;

	// The unused kind code, which the block drops without a result.
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
	// Cycles to let the back end finish before a register write or the end.
	localparam int SETTLE_CYCLES = 64;
	// Long receiver hold-off in the pressure phase.
	localparam int HOLD_CYCLES = 200;
	// Cycles without any transfer before the run is abandoned.
	localparam int QUIET_LIMIT = 2000;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [KEY_W-1:0]  key;
	} stream_item_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [KIND_W-1:0]     s_axis_tuser = KIND_LOAD;
	logic [KEY_W-1:0]      s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [STAT_W-1:0]     m_axis_tuser;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic                  cfg_index = 1'b0;
	logic [ENT_W-1:0]      cfg_data = '0;

	// Items waiting for the driver, and results the block still owes.
	stream_item_t key_items [$];
	result_t      due_results [$];
	logic [KEY_W-1:0] run_keys [$];
	stream_item_t offer;
	result_t      want;

	int stim_items = 0;
	int fails = 0;
	int send_idle = 0;
	int recv_stall = 0;
	bit hold_arm = 1'b0;
	int hold_count = 0;
	int quiet_cycles = 0;

	// Predictor copy of the registers and of the list and plan state.
	logic [ENT_W-1:0] min_reg = 17'd1;
	logic [CAP_W-1:0] cap_reg = 6'd32;
	logic [KEY_W-1:0] last_key = '0;
	int unsigned      key_total = 0;
	int unsigned      fill = 0;
	int unsigned      groups = 0;
	int unsigned      plan_shards = 0;
	logic             unsorted = 1'b0;
	logic [KEY_W-1:0] starts [MAX_SHARDS];

	sorted_key_range_partitioner_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic queue_result(input status_t st, input int unsigned idx,
			input logic [KEY_W-1:0] fk, input longint unsigned ent,
			input int unsigned cnt, input logic lst);
		result_t r;
		r.status      = st;
		r.shard_index = IDX_W'(idx);
		r.first_key   = fk;
		r.entries     = ENT_W'(ent);
		r.shard_count = CNT_W'(cnt);
		r.last        = lst;
		due_results.push_back(r);
	endtask

	// Work out the results of one accepted item and advance the list state.
	task automatic partition_step(input logic [KIND_W-1:0] kind,
			input logic [KEY_W-1:0] key);
		int unsigned mn;
		int unsigned cap;
		int unsigned shards;
		int unsigned count;
		int unsigned found;
		longint unsigned used;
		longint unsigned ent;
		logic bad;
		mn = (min_reg == 0) ? 1 : min_reg;
		case (kind)
			KIND_LOAD: begin
				plan_shards = 0;
				if (key_total > 0 && key < last_key)
					unsorted = 1'b1;
				last_key = key;
				if (key_total <= MAX_KEYS)
					key_total++;
				if (fill == 0 && groups < MAX_SHARDS)
					starts[groups[IDX_W-1:0]] = key;
				fill++;
				if (fill >= mn) begin
					fill = 0;
					if (groups <= MAX_SHARDS)
						groups++;
				end
			end
			KIND_END: begin
				cap = (cap_reg > MAX_SHARDS) ? MAX_SHARDS : cap_reg;
				shards = (groups == 0) ? 1 : groups;
				count = key_total;
				bad = unsorted;
				last_key = '0;
				key_total = 0;
				fill = 0;
				groups = 0;
				unsorted = 1'b0;
				plan_shards = 0;
				if (bad) begin
					queue_result(ST_UNSORTED, 0, '0, 0, 0, 1'b1);
				end else if (count > MAX_KEYS) begin
					queue_result(ST_RANGE, 0, '0, 0, 0, 1'b1);
				end else if (count == 0) begin
					queue_result(ST_OK, 0, '0, 0, 0, 1'b1);
				end else if (shards > cap) begin
					queue_result(ST_RANGE, 0, '0, 0, 0, 1'b1);
				end else begin
					// Full shards hold mn keys; the last one takes what is left.
					for (int i = 0; i < shards; i++) begin
						if (i + 1 == shards) begin
							used = longint'(shards - 1) * mn;
							ent = (count > used) ? count - used : 0;
						end else begin
							ent = mn;
						end
						queue_result(ST_OK, i, starts[i[IDX_W-1:0]], ent, shards,
							i + 1 == shards);
					end
					plan_shards = shards;
				end
			end
			KIND_QUERY: begin
				if (plan_shards == 0) begin
					queue_result(ST_ABSENT, 0, '0, 0, 0, 1'b1);
				end else begin
					found = 0;
					for (int i = 0; i < plan_shards && i < MAX_SHARDS; i++)
						if (key >= starts[i[IDX_W-1:0]])
							found = i;
					queue_result(ST_OK, found, starts[found[IDX_W-1:0]], 0, plan_shards,
						1'b1);
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [KEY_W-1:0] want_v,
			input logic [KEY_W-1:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
			fails++;
		end
	endtask

	// Input driver: hold an item until its transfer, then offer the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tuser <= KIND_LOAD;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				partition_step(s_axis_tuser, s_axis_tdata);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (key_items.size() != 0 && $urandom_range(99) >= send_idle) begin
					offer = key_items.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= offer.kind;
					s_axis_tdata <= offer.key;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off once armed.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_count <= 0;
		end else if (hold_arm && hold_count < HOLD_CYCLES) begin
			m_axis_tready <= 1'b0;
			hold_count <= hold_count + 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// Result monitor: compare each transfer with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (due_results.size() == 0) begin
				$error("result transfer with nothing expected: status %0d", m_axis_tuser);
				fails++;
			end else begin
				want = due_results.pop_front();
				check_field("status", KEY_W'(want.status), KEY_W'(m_axis_tuser));
				check_field("shard_index", KEY_W'(want.shard_index),
					KEY_W'(m_axis_tdata[IDX_W-1:0]));
				check_field("first_key", want.first_key, m_axis_tdata[IDX_W +: KEY_W]);
				check_field("entries", KEY_W'(want.entries),
					KEY_W'(m_axis_tdata[IDX_W+KEY_W +: ENT_W]));
				check_field("shard_count", KEY_W'(want.shard_count),
					KEY_W'(m_axis_tdata[IDX_W+KEY_W+ENT_W +: CNT_W]));
				check_field("last", KEY_W'(want.last), KEY_W'(m_axis_tlast));
			end
		end
	end

	// Watchdog: give up after a long stretch with no transfer anywhere.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("sorted_key_range_partitioner_core: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key);
		stream_item_t it;
		it.kind = kind;
		it.key = key;
		key_items.push_back(it);
		if (kind != KIND_SPARE)
			stim_items++;
	endtask

	// Queue n sorted load keys, pulled down so the run cannot wrap.
	task automatic load_run(input int n, input logic [KEY_W-1:0] base,
			input logic [KEY_W-1:0] step);
		logic [KEY_W-1:0] top;
		top = ~64'd0 - step * 64'(n);
		if (base > top)
			base = top;
		run_keys.delete();
		for (int i = 0; i < n; i++) begin
			run_keys.push_back(base + step * 64'(i));
			send(KIND_LOAD, base + step * 64'(i));
		end
	endtask

	// Wait until every item is taken and every result is in, then let it settle.
	task automatic settle();
		while (key_items.size() != 0 || s_axis_tvalid || due_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [ENT_W-1:0] value);
		settle();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_SHARD_SIZE)
			min_reg = value;
		else
			cap_reg = value[CAP_W-1:0];
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [KEY_W-1:0] pick_probe();
		logic [KEY_W-1:0] probe;
		case ($urandom_range(3))
			0: probe = {$urandom, $urandom};
			1: probe = $urandom_range(1) ? '1 : '0;
			default: begin
				if (run_keys.size() != 0)
					probe = run_keys[$urandom_range(run_keys.size() - 1)]
						+ 64'($urandom_range(2)) - 64'd1;
				else
					probe = {$urandom, $urandom};
			end
		endcase
		return probe;
	endfunction

	// One random sequence: mostly a sorted list, its end and some queries.
	task automatic random_sequence();
		logic [KEY_W-1:0] base;
		logic [KEY_W-1:0] step;
		logic [KEY_W-1:0] last;
		int n;
		int roll;
		roll = $urandom_range(99);
		n = ($urandom_range(7) == 0) ? $urandom_range(13, 32) : $urandom_range(0, 10);
		step = ($urandom_range(3) == 0) ? 64'($urandom) : 64'($urandom_range(3));
		case ($urandom_range(3))
			0: base = '0;
			1: base = '1;
			default: base = {$urandom, $urandom};
		endcase
		if (roll < 12) begin
			// Stray items outside any list.
			case ($urandom_range(2))
				0: send(KIND_SPARE, {$urandom, $urandom});
				1: send(KIND_QUERY, {$urandom, $urandom});
				default: send(KIND_END, {$urandom, $urandom});
			endcase
		end else begin
			load_run(n, base, step);
			if (roll < 27) begin
				// Break the ordering with a key below the previous one.
				last = (n > 0) ? run_keys[$] : '0;
				if (last == 0) begin
					send(KIND_LOAD, '1);
					send(KIND_LOAD, '0);
				end else begin
					send(KIND_LOAD, last - 64'd1);
				end
			end else if (roll < 37) begin
				// A query while a list is open finds no plan.
				send(KIND_QUERY, {$urandom, $urandom});
				if (n > 0)
					repeat ($urandom_range(1, 2)) send(KIND_LOAD, run_keys[$]);
			end
			send(KIND_END, {$urandom, $urandom});
			repeat ($urandom_range(1, 4)) send(KIND_QUERY, pick_probe());
		end
	endtask

	initial begin : stimulus
		logic [ENT_W-1:0] value;
		int target;
		for (int i = 0; i < MAX_SHARDS; i++)
			starts[i[IDX_W-1:0]] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// No plan after reset, an empty list, and the unused kind.
		send(KIND_QUERY, {$urandom, $urandom});
		send(KIND_END, '1);
		send(KIND_SPARE, '1);
		// A small plan with equal keys and the largest key, then lookups.
		send(KIND_LOAD, '0);
		send(KIND_LOAD, 64'd5);
		send(KIND_LOAD, 64'd5);
		send(KIND_LOAD, '1);
		send(KIND_END, '0);
		send(KIND_QUERY, '0);
		send(KIND_QUERY, 64'd5);
		send(KIND_QUERY, 64'd4);
		send(KIND_QUERY, '1);
		// A load drops the plan; an inversion fails the list.
		send(KIND_LOAD, 64'd100);
		send(KIND_QUERY, 64'd100);
		send(KIND_LOAD, 64'd50);
		send(KIND_END, '0);
		send(KIND_QUERY, '0);

		// Zero capacity rejects a list but not an empty one.
		write_reg(REG_SHARD_CAPACITY, '0);
		send(KIND_LOAD, 64'd7);
		send(KIND_END, '0);
		send(KIND_END, '0);
		// Capacity above the maximum acts as the maximum; the group count saturates.
		write_reg(REG_SHARD_CAPACITY, 17'd63);
		load_run(MAX_SHARDS + 1, 64'd1, 64'd3);
		send(KIND_END, '0);
		write_reg(REG_SHARD_CAPACITY, 17'd32);
		// The shard size changes while a list is open.
		write_reg(REG_SHARD_SIZE, 17'd4);
		load_run(6, 64'd1000, 64'd10);
		write_reg(REG_SHARD_SIZE, 17'd1);
		send(KIND_LOAD, 64'd2000);
		send(KIND_END, '0);
		load_run(3, 64'd10, 64'd1);
		write_reg(REG_SHARD_SIZE, 17'd5);
		send(KIND_END, '0);
		send(KIND_QUERY, 64'd11);
		// A zero shard size acts as one.
		write_reg(REG_SHARD_SIZE, '0);
		load_run(3, '1, 64'd2);
		send(KIND_END, '0);
		// Largest shard size with a single shard allowed.
		write_reg(REG_SHARD_SIZE, 17'd65536);
		write_reg(REG_SHARD_CAPACITY, 17'd1);
		load_run(3, {$urandom, $urandom}, 64'd1);
		send(KIND_END, '0);
		send(KIND_QUERY, '1);

		// Random lists under each idling pattern.
		for (int ph = 0; ph < 4; ph++) begin
			settle();
			case (ph)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 51; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 51; end
				default: begin send_idle = 24; recv_stall = 24; end
			endcase
			target = stim_items + 4;
			while (stim_items < target) begin
				case ($urandom_range(7))
					0: value = '0;
					1: value = 17'd1;
					2: value = 17'd2;
					3: value = 17'd3;
					4: value = 17'($urandom);
					default: value = 17'($urandom_range(1, 5));
				endcase
				write_reg(REG_SHARD_SIZE, value);
				case ($urandom_range(7))
					0: value = '0;
					1: value = 17'd1;
					2: value = 17'h1FFE0;
					3: value = 17'd63;
					4: value = 17'($urandom);
					default: value = 17'd32;
				endcase
				write_reg(REG_SHARD_CAPACITY, value);
				random_sequence();
			end
		end

		// Pressure: the receiver holds off while a full plan and queries pile up.
		settle();
		send_idle = 0;
		recv_stall = 0;
		write_reg(REG_SHARD_SIZE, 17'd1);
		write_reg(REG_SHARD_CAPACITY, 17'd32);
		hold_arm = 1'b1;
		// A full plan reaches the highest shard index.
		load_run(MAX_SHARDS, {$urandom, $urandom}, 64'($urandom));
		send(KIND_END, '0);
		send(KIND_QUERY, '1);
		send(KIND_QUERY, run_keys[10]);
		repeat (4) send(KIND_QUERY, pick_probe());

		settle();
		if (fails == 0)
			$display("sorted_key_range_partitioner_core: match");
		else
			$display("sorted_key_range_partitioner_core: mismatch");
		$finish;
	end

endmodule
